// ----- design/unsigned_divide_modulo_32_defines.svh -----
// assertion macros for the divider
`ifndef UNSIGNED_DIVIDE_MODULO_32_DEFINES_SVH
`define UNSIGNED_DIVIDE_MODULO_32_DEFINES_SVH

// same-cycle implication, checked outside reset
`define UDM_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("divider check failed");

// next-cycle implication, checked outside reset
`define UDM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("divider check failed");

`endif

// ----- design/udm_pkg.sv -----
package udm_pkg;

  typedef struct packed {
    logic [31:0] dividend;
    logic [31:0] divisor;
  } udm_in_t;

  typedef struct packed {
    logic [31:0] quotient;
    logic [31:0] remainder;
    logic        divide_by_zero;
  } udm_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } udm_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
  } udm_cmd_t;

endpackage

// ----- design/udm_ctrl.sv -----
module udm_ctrl
  import udm_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  output logic     done,
  output udm_cmd_t cmd
);

  localparam int CW = (WIDTH > 2) ? $clog2(WIDTH) : 1;

  udm_state_t    state, state_next;
  logic [CW-1:0] count, count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_comb begin
    state_next = state;
    count_next = count;
    cmd        = '0;
    busy       = 1'b0;
    done       = 1'b0;
    unique case (state) inside
      ST_IDLE, ST_DONE: begin
        done = (state == ST_DONE);
        if (start) begin
          cmd.load   = 1'b1;
          count_next = CW'(WIDTH - 1);
          state_next = ST_RUN;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_RUN: begin
        busy     = 1'b1;
        cmd.step = 1'b1;
        if (count == '0) begin
          state_next = ST_DONE;
        end else begin
          count_next = count - 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- design/udm_dp.sv -----
module udm_dp
  import udm_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic     clk,
  input  udm_cmd_t cmd,
  input  udm_in_t  request,
  output udm_out_t result
);

  logic [WIDTH-1:0] rem;
  logic [WIDTH-1:0] quo;
  logic [WIDTH-1:0] den;
  logic             dz;
  logic [WIDTH:0]   shifted;
  logic [WIDTH+1:0] diff;

  // restoring step: shift in next dividend bit, trial subtract
  always_comb begin
    shifted = {rem, quo[WIDTH-1]};
    diff    = {1'b0, shifted} - {2'b00, den};
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem <= '0;
      quo <= WIDTH'(request.dividend);
      den <= WIDTH'(request.divisor);
      dz  <= (WIDTH'(request.divisor) == '0);
    end else if (cmd.step) begin
      if (diff[WIDTH+1]) begin
        rem <= shifted[WIDTH-1:0];
      end else begin
        rem <= diff[WIDTH-1:0];
      end
      quo <= {quo[WIDTH-2:0], ~diff[WIDTH+1]};
    end
  end

  // zero divisor falls out of the loop: all ones quotient, dividend remainder
  always_comb begin
    result.quotient       = 32'(quo);
    result.remainder      = 32'(rem);
    result.divide_by_zero = dz;
  end

endmodule

// ----- design/unsigned_divide_modulo_32.sv -----
// channel    | handshake            | payload
// -----------+----------------------+--------------------------------
// operands   | start high, busy low | request (dividend, divisor)
// result     | done strobe, 1 cycle | result (quotient, remainder,
//            |                      |         divide_by_zero)
//
// from acceptance to the done strobe, the radix-2 restoring loop retires
// one quotient bit a cycle
// a new transaction may be accepted in the cycle that done is high
// synchronous reset returns the controller to idle; datapath registers
// carry no reset
// the receiver cannot stall: each result is shown for exactly one cycle
module unsigned_divide_modulo_32
  import udm_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  udm_in_t  request,
  output logic     done,
  output udm_out_t result
);

`include "unsigned_divide_modulo_32_defines.svh"

  // command bundle from the sequencer to the shift/subtract datapath
  udm_cmd_t cmd;

  // controller: idle, WIDTH iterations, then a one-cycle result strobe
  udm_ctrl #(
    .WIDTH (WIDTH)
  ) u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  // datapath: partial remainder, quotient/dividend shift register, divisor
  udm_dp #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk     (clk),
    .cmd     (cmd),
    .request (request),
    .result  (result)
  );

  // a result strobe never overlaps the iteration phase
  `UDM_ASSERT_SAME(a_done_not_busy, done, !busy)
  // an accepted transaction always starts iterating
  `UDM_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  // the result strobe lasts exactly one cycle
  `UDM_ASSERT_NEXT(a_done_single, done, !done)

endmodule

// ----- tb/sv/udm_division_checker.sv -----
`timescale 1ns / 1ps

module udm_division_checker
  import udm_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  logic     busy,
  input  udm_in_t  request,
  input  logic     done,
  input  udm_out_t result,
  output int       fail_count,
  output int       outstanding
);

  udm_out_t pending_results[$];
  udm_out_t oldest;

  // floor quotient and remainder, zero divisor flagged
  function automatic udm_out_t divide_floor(input udm_in_t op);
    udm_out_t r;
    if (op.divisor == '0) begin
      r.quotient       = '1;
      r.remainder      = op.dividend;
      r.divide_by_zero = 1'b1;
    end else begin
      r.quotient       = op.dividend / op.divisor;
      r.remainder      = op.dividend % op.divisor;
      r.divide_by_zero = 1'b0;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        pending_results.push_back(divide_floor(request));
      end
      if (done) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: quotient %h remainder %h divide_by_zero %b",
                 result.quotient, result.remainder, result.divide_by_zero);
          fail_count++;
        end else begin
          oldest = pending_results.pop_front();
          if (result.quotient !== oldest.quotient) begin
            $error("quotient mismatch: expected %h, got %h",
                   oldest.quotient, result.quotient);
            fail_count++;
          end
          if (result.remainder !== oldest.remainder) begin
            $error("remainder mismatch: expected %h, got %h",
                   oldest.remainder, result.remainder);
            fail_count++;
          end
          if (result.divide_by_zero !== oldest.divide_by_zero) begin
            $error("divide_by_zero mismatch: expected %b, got %b",
                   oldest.divide_by_zero, result.divide_by_zero);
            fail_count++;
          end
        end
      end
      outstanding = pending_results.size();
    end
  end

endmodule

// ----- tb/sv/tb_unsigned_divide_modulo_32.sv -----
`timescale 1ns / 1ps

module tb_unsigned_divide_modulo_32;
  import udm_pkg::*;

  // transaction counts and end-of-run waits
  localparam int RANDOM_TRANSACTIONS = 1750;
  localparam int DRAIN_LIMIT         = 400;  // well over the time one transaction takes
  localparam int TAIL_CYCLES         = 40;   // catches any stray late strobe

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  logic     done;
  udm_in_t  request;
  udm_out_t result;

  int fail_count;
  int outstanding;

  unsigned_divide_modulo_32 #(
    .WIDTH(32)
  ) uut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .request(request),
    .done   (done),
    .result (result)
  );

  // watches both channels, predicts and compares
  udm_division_checker checker_inst (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .request    (request),
    .done       (done),
    .result     (result),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  // 2 ns clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // hard stop: the slowest legal run is a few hundred microseconds
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // offer one operand pair and hold it until the block takes it;
  // busy is read just after the edge, so it is the value the edge saw
  task automatic issue_division(input logic [31:0] num, input logic [31:0] den);
    udm_in_t op;
    op.dividend = num;
    op.divisor  = den;
    start   <= 1'b1;
    request <= op;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // operand mix: tiny values, values near the top, single set bits,
  // values of random bit length (many divisors below 65536) and full words
  function automatic logic [31:0] pick_operand();
    logic [31:0] v;
    case ($urandom_range(0, 9)) inside
      0: begin
        v = $urandom_range(0, 3);
      end
      1: begin
        v = 32'hffff_ffff - $urandom_range(0, 3);
      end
      2: begin
        v = 32'h1 << $urandom_range(0, 31);
      end
      [3:5]: begin
        v = $urandom >> $urandom_range(0, 31);
      end
      default: begin
        v = $urandom;
      end
    endcase
    return v;
  endfunction

  initial begin
    logic [31:0] num;
    logic [31:0] den;
    int          issued;
    int          burst_left;
    int          gap;
    int          waited;

    // everything known from time zero
    rst     = 1'b1;
    start   = 1'b0;
    request = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corners, issued back to back with no idling
    issue_division(32'h0000_0000, 32'h0000_0000);  // zero over zero
    issue_division(32'hffff_ffff, 32'h0000_0000);  // zero divisor, full dividend
    issue_division(32'h1234_5678, 32'h0000_0000);
    issue_division(32'h0000_0000, 32'h0000_0001);
    issue_division(32'hffff_ffff, 32'h0000_0001);  // largest quotient
    issue_division(32'hffff_ffff, 32'hffff_ffff);
    issue_division(32'hffff_fffe, 32'hffff_ffff);  // dividend just below divisor
    issue_division(32'h0000_0005, 32'hffff_ffff);
    issue_division(32'h0000_0000, 32'hffff_ffff);
    issue_division(32'hffff_ffff, 32'h0001_0000);  // smallest divisor wider than 16 bits
    issue_division(32'hffff_ffff, 32'h0000_ffff);  // largest 16-bit divisor
    issue_division(32'hffff_ffff, 32'h0000_0002);
    issue_division(32'hffff_ffff, 32'h0000_0003);
    issue_division(32'h8000_0000, 32'h0000_0001);
    issue_division(32'h0000_0001, 32'h8000_0000);
    issue_division(32'h8000_0000, 32'h8000_0000);  // equal operands
    issue_division(32'h1234_5678, 32'h0000_1234);
    issue_division(32'haaaa_aaaa, 32'h5555_5555);
    issue_division(32'h5555_5555, 32'haaaa_aaaa);
    issue_division(32'hfffe_0001, 32'h0000_ffff);  // exact square of 0xffff
    issue_division(32'h0001_0000, 32'h0000_0100);

    // random part: bursts of random length, gaps of random length between
    // them; long gaps let the block sit idle, zero gaps keep it saturated
    issued = 0;
    while (issued < RANDOM_TRANSACTIONS) begin
      burst_left = $urandom_range(1, 24);
      while (burst_left > 0 && issued < RANDOM_TRANSACTIONS) begin
        den = ($urandom_range(0, 19) == 0) ? 32'h0 : pick_operand();
        if ($urandom_range(0, 7) == 0) begin
          // near a multiple of the divisor: remainder at zero or its extremes
          num = den * $urandom_range(0, 300) + ($urandom_range(0, 2) - 1);
        end else begin
          num = pick_operand();
        end
        issue_division(num, den);
        burst_left--;
        issued++;
      end
      if ($urandom_range(0, 3) != 0) begin
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 45) : $urandom_range(1, 6);
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    start <= 1'b0;

    // drain: wait for every outstanding transaction, sampled away from the edge
    waited = 0;
    while (outstanding != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);

    if (fail_count == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
